[rtl/core/tcw_pkg.sv]
// tcw_pkg: shared constants, operation codes and control types of the text console writer
// no dependencies
`default_nettype none

package tcw_pkg;

	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	localparam int ROW_W   = 5;
	localparam int COL_W   = 7;
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 8;
	localparam int CELL_W  = 16;
	localparam int FUNC_W  = 2;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd3;

	localparam logic [0:0] REG_TEXT_COLOR = 1'b0;

	localparam logic [CHAR_W-1:0]  NEWLINE          = 8'd10;
	localparam logic [CELL_W-1:0]  BLANK_GREY       = 16'h0720;
	localparam logic [CELL_W-1:0]  BLANK_WHITE      = 16'h0F20;
	localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET = 8'h07;

	typedef struct packed {
		logic accept;
		logic load_now;
		logic load_out;
		logic start_clear;
		logic start_scroll;
		logic sweep_run;
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              needs_scroll;
		logic              sweep_last;
		logic              out_full;
	} stat_t;

endpackage

`default_nettype wire

[rtl/core/tcw_ctrl.sv]
// tcw_ctrl: operation sequencer of the text console writer
// depends on tcw_pkg; drives tcw_datapath through cmd_t and reads stat_t
`default_nettype none

module tcw_ctrl
	import tcw_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire logic  out_ready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	localparam logic [2:0] ST_INIT      = 3'd0;
	localparam logic [2:0] ST_INIT_END  = 3'd1;
	localparam logic [2:0] ST_IDLE      = 3'd2;
	localparam logic [2:0] ST_READ      = 3'd3;
	localparam logic [2:0] ST_SWEEP     = 3'd4;
	localparam logic [2:0] ST_SWEEP_END = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		state_nxt = state_q;
		unique case (state_q)
			ST_INIT: begin
				cmd.sweep_run = 1'b1;
				if (stat.sweep_last) begin
					state_nxt = ST_INIT_END;
				end
			end
			ST_INIT_END: begin
				state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready   = !stat.out_full || out_ready;
				cmd.accept = in_valid && in_ready;
				if (cmd.accept) begin
					unique case (stat.func) inside
						FUNC_READ: begin
							state_nxt = ST_READ;
						end
						FUNC_CLEAR: begin
							cmd.start_clear = 1'b1;
							state_nxt       = ST_SWEEP;
						end
						FUNC_PUT, FUNC_WRITE: begin
							if (stat.func == FUNC_PUT && stat.needs_scroll) begin
								cmd.start_scroll = 1'b1;
								state_nxt        = ST_SWEEP;
							end else begin
								cmd.load_now = 1'b1;
							end
						end
					endcase
				end
			end
			ST_READ: begin
				cmd.load_out = 1'b1;
				state_nxt    = ST_IDLE;
			end
			ST_SWEEP: begin
				cmd.sweep_run = 1'b1;
				if (stat.sweep_last) begin
					state_nxt = ST_SWEEP_END;
				end
			end
			ST_SWEEP_END: begin
				cmd.load_out = 1'b1;
				state_nxt    = ST_IDLE;
			end
			default: begin
				state_nxt = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

[rtl/core/tcw_datapath.sv]
// tcw_datapath: cell store, cursor, sweep engine and result register of the text console writer
// depends on tcw_pkg; commanded by tcw_ctrl
`default_nettype none

module tcw_datapath
	import tcw_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	output stat_t                   stat,
	input  wire logic [COLOR_W-1:0] text_color,
	input  wire logic [FUNC_W-1:0]  func,
	input  wire logic [CHAR_W-1:0]  char_code,
	input  wire logic [COLOR_W-1:0] cell_color,
	input  wire logic [COL_W-1:0]   pos_column,
	input  wire logic [ROW_W-1:0]   pos_row,
	input  wire logic               out_ready,
	output logic                    out_valid,
	output logic [CELL_W-1:0]       out_read_data,
	output logic [ROW_W-1:0]        out_cursor_row,
	output logic [COL_W-1:0]        out_cursor_column,
	output logic                    out_did_scroll,
	output logic                    out_bad_position
);

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int PROD_W = ROW_W + COL_W + 1;
	localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] FILL_BASE = ADDR_W'(CELLS - COLUMNS);
	localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
	localparam logic [ROW_W:0]    ROWS_X    = (ROW_W + 1)'(ROWS);
	localparam logic [COL_W:0]    COLS_X    = (COL_W + 1)'(COLUMNS);
	localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

	logic [CELL_W-1:0] mem [CELLS];
	logic [CELL_W-1:0] rdata_q;

	logic [ROW_W-1:0]  cur_row_q;
	logic [COL_W-1:0]  cur_col_q;

	logic [ADDR_W-1:0] cnt_q;
	logic              mode_clear_q;

	logic              wr_valid_s1;
	logic [ADDR_W-1:0] wr_addr_s1;
	logic              blank_s1;
	logic [CELL_W-1:0] blank_val_s1;

	logic              rd_pend_q;
	logic              bad_pend_q;
	logic              scroll_pend_q;

	logic              out_valid_q;
	logic [CELL_W-1:0] out_read_data_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [COL_W-1:0]  out_col_q;
	logic              out_scroll_q;
	logic              out_bad_q;

	logic              pos_inside;
	logic [ADDR_W-1:0] pos_addr;
	logic [ADDR_W-1:0] cur_addr;
	logic [COL_W:0]    col_inc;
	logic [ROW_W:0]    row_inc;
	logic              is_nl;
	logic              wrap;
	logic              put_scroll;
	logic [ROW_W-1:0]  row_nxt;
	logic [COL_W-1:0]  col_nxt;
	logic              copy;
	logic              scroll_now;
	logic              bad_now;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	logic [CELL_W-1:0] mem_wd;
	logic [ADDR_W-1:0] mem_ra;

	// position decode and cursor stepping
	always_comb begin
		pos_inside = ({1'b0, pos_column} < COLS_X) && ({1'b0, pos_row} < ROWS_X);
		pos_addr   = pos_inside
			? ADDR_W'(PROD_W'(pos_row) * PROD_W'(COLUMNS) + PROD_W'(pos_column)) : '0;
		cur_addr   = ADDR_W'(PROD_W'(cur_row_q) * PROD_W'(COLUMNS) + PROD_W'(cur_col_q));
		col_inc    = {1'b0, cur_col_q} + 1'b1;
		row_inc    = {1'b0, cur_row_q} + 1'b1;
		is_nl      = char_code == NEWLINE;
		wrap       = is_nl || (col_inc >= COLS_X);
		put_scroll = wrap && (row_inc >= ROWS_X);
		scroll_now = (func == FUNC_PUT) && put_scroll;
		bad_now    = (func == FUNC_WRITE || func == FUNC_READ) && !pos_inside;
		row_nxt    = cur_row_q;
		col_nxt    = cur_col_q;
		case (func)
			FUNC_PUT: begin
				if (wrap) begin
					col_nxt = '0;
					row_nxt = put_scroll ? LAST_ROW : row_inc[ROW_W-1:0];
				end else begin
					col_nxt = col_inc[COL_W-1:0];
				end
			end
			FUNC_CLEAR: begin
				row_nxt = '0;
				col_nxt = '0;
			end
			default: begin
				row_nxt = cur_row_q;
				col_nxt = cur_col_q;
			end
		endcase
	end

	// store port selection
	always_comb begin
		copy   = !mode_clear_q && (cnt_q < FILL_BASE);
		mem_ra = (cmd.sweep_run && copy) ? cnt_q + ROW_STEP
			: (cmd.sweep_run ? '0 : pos_addr);
		mem_we = 1'b0;
		mem_wa = cur_addr;
		mem_wd = {text_color, char_code};
		if (wr_valid_s1) begin
			mem_we = 1'b1;
			mem_wa = wr_addr_s1;
			mem_wd = blank_s1 ? blank_val_s1 : rdata_q;
		end else if (cmd.accept && func == FUNC_PUT && !is_nl) begin
			mem_we = 1'b1;
		end else if (cmd.accept && func == FUNC_WRITE && pos_inside) begin
			mem_we = 1'b1;
			mem_wa = pos_addr;
			mem_wd = {cell_color, char_code};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q    <= '0;
			cur_col_q    <= '0;
			cnt_q        <= '0;
			mode_clear_q <= 1'b1;
			wr_valid_s1  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.accept) begin
				cur_row_q <= row_nxt;
				cur_col_q <= col_nxt;
			end
			if (cmd.start_clear || cmd.start_scroll) begin
				cnt_q        <= '0;
				mode_clear_q <= cmd.start_clear;
			end else if (cmd.sweep_run) begin
				cnt_q <= cnt_q + 1'b1;
			end
			wr_valid_s1 <= cmd.sweep_run;
			if (cmd.load_now || cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1   <= cnt_q;
		blank_s1     <= !copy;
		blank_val_s1 <= mode_clear_q ? BLANK_GREY : BLANK_WHITE;
		if (cmd.accept) begin
			rd_pend_q     <= (func == FUNC_READ) && pos_inside;
			bad_pend_q    <= bad_now;
			scroll_pend_q <= scroll_now;
		end
		if (cmd.load_now) begin
			out_read_data_q <= '0;
			out_row_q       <= row_nxt;
			out_col_q       <= col_nxt;
			out_scroll_q    <= scroll_now;
			out_bad_q       <= bad_now;
		end else if (cmd.load_out) begin
			out_read_data_q <= rd_pend_q ? rdata_q : '0;
			out_row_q       <= cur_row_q;
			out_col_q       <= cur_col_q;
			out_scroll_q    <= scroll_pend_q;
			out_bad_q       <= bad_pend_q;
		end
	end

	assign stat.func         = func;
	assign stat.needs_scroll = put_scroll;
	assign stat.sweep_last   = cnt_q == LAST_CELL;
	assign stat.out_full     = out_valid_q;

	assign out_valid         = out_valid_q;
	assign out_read_data     = out_read_data_q;
	assign out_cursor_row    = out_row_q;
	assign out_cursor_column = out_col_q;
	assign out_did_scroll    = out_scroll_q;
	assign out_bad_position  = out_bad_q;

endmodule

`default_nettype wire

[rtl/core/text_console_writer.sv]
// Text console writer over a ROWS x COLUMNS store of 16-bit cells (color high byte, character
// low byte) with a cursor. Put character and write at position are taken back to back while
// the result output is not stalled; read cell also passes through a read state that waits for
// the registered read of the cell store. Clear and a put character that leaves the last row
// walk the whole store one cell per cycle, and no beat is taken until that walk is done. After
// reset the store is cleared the same way and no beat is taken before that is done;
// the text_color register can be written over the APB port at any time the block is idle.
// top level; depends on tcw_pkg, tcw_ctrl and tcw_datapath
`default_nettype none

module text_console_writer
	import tcw_pkg::*;
#(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// char_code[7:0], cell_color[15:8], pos_column[22:16], pos_row[27:23]
	input  wire logic [31:0]           s_axis_tdata,
	// func[1:0]
	input  wire logic [FUNC_W-1:0]     s_axis_tuser,
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// read_data[15:0], cursor_row[20:16], cursor_column[27:21], did_scroll[28],
	// bad_position[29]
	output logic [31:0]                m_axis_tdata,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0]      prdata,
	output logic                       pready
);

	logic [COLOR_W-1:0] text_color_q;
	logic               reg_sel;

	cmd_t               cmd;
	stat_t              stat;

	logic [CELL_W-1:0]  read_data;
	logic [ROW_W-1:0]   cursor_row;
	logic [COL_W-1:0]   cursor_column;
	logic               did_scroll;
	logic               bad_position;

	// register file
	assign reg_sel = paddr[CFG_ADDR_W-1:2] == REG_TEXT_COLOR;
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? CFG_DATA_W'(text_color_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= TEXT_COLOR_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			text_color_q <= pwdata[COLOR_W-1:0];
		end
	end

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tcw_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.text_color        (text_color_q),
		.func              (s_axis_tuser),
		.char_code         (s_axis_tdata[7:0]),
		.cell_color        (s_axis_tdata[15:8]),
		.pos_column        (s_axis_tdata[22:16]),
		.pos_row           (s_axis_tdata[27:23]),
		.out_ready         (m_axis_tready),
		.out_valid         (m_axis_tvalid),
		.out_read_data     (read_data),
		.out_cursor_row    (cursor_row),
		.out_cursor_column (cursor_column),
		.out_did_scroll    (did_scroll),
		.out_bad_position  (bad_position)
	);

	assign m_axis_tdata = {2'b00, bad_position, did_scroll, cursor_column, cursor_row, read_data};

`ifndef ASSERT_OFF
	localparam logic [ROW_W:0] ROWS_CHK = (ROW_W + 1)'(ROWS);
	localparam logic [COL_W:0] COLS_CHK = (COL_W + 1)'(COLUMNS);
	localparam logic [ROW_W-1:0] LAST_ROW_CHK = ROW_W'(ROWS - 1);

	a_no_take_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while result beat is stalled");

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ({1'b0, cursor_row} < ROWS_CHK && {1'b0, cursor_column} < COLS_CHK))
		else $error("cursor outside the screen");

	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && did_scroll) |-> (cursor_row == LAST_ROW_CHK && cursor_column == '0))
		else $error("scroll left cursor off the start of the last row");

	a_bad_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && bad_position) |-> (read_data == '0 && !did_scroll))
		else $error("bad position beat carries data or scroll");
`endif

endmodule

`default_nettype wire
